### rtl/esip_pkg.sv
package esip_pkg;

  // Item commands.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_EDGE = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_UNIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_NUMERATOR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_PULSE_UNITS = 2'd3;
  localparam int unsigned CFG_DATA_W = 24;

  // Register reset values.
  localparam logic [7:0]  TICKS_PER_UNIT_RST   = 8'd5;
  localparam logic [15:0] PERIOD_LIMIT_RST     = 16'd60000;
  localparam logic [23:0] SPEED_NUMERATOR_RST  = 24'd6000000;
  localparam logic [7:0]  BASE_PULSE_UNITS_RST = 8'd25;

  // The dividend is speed_numerator / 2, so one quotient bit per step over 23 bits.
  localparam int unsigned DIV_STEPS = 23;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [15:0] SPEED_MAX = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tick_go;   // a tick word is accepted
    logic edge_go;   // an edge word is accepted, division starts
    logic div_step;  // one restoring division step
    logic div_done;  // last division step, result goes out
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_full;  // output register holds a word that is not taken now
  } dp_sts_t;

endpackage

### rtl/esip_ctrl.sv
module esip_ctrl import esip_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       command_i,
  input  dp_sts_t    sts_i,
  output logic       in_stall_o,
  output ctrl_cmd_t  cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DIV  = 1'b1;

  logic                 state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 accept;
  logic                 last_step;

  assign in_stall_o = (state_q != S_IDLE) || sts_i.out_full;
  assign accept     = in_valid_i && !in_stall_o;
  assign last_step  = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

  always_comb begin
    cmd_o          = '0;
    cmd_o.tick_go  = accept && (command_i == CMD_TICK);
    cmd_o.edge_go  = accept && (command_i == CMD_EDGE);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.div_done = (state_q == S_DIV) && last_step;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.edge_go) begin
          state_d = S_DIV;
          cnt_d   = '0;
        end
      end
      S_DIV: begin
        if (last_step) begin
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_div_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> in_stall_o)
    else $error("input not stalled during division");

  a_edge_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.edge_go |=> (state_q == S_DIV) && (cnt_q == '0))
    else $error("edge word did not start the division");

  a_done_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_done |=> (state_q == S_IDLE))
    else $error("controller did not return to idle after division");

  a_out_free_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> !sts_i.out_full)
    else $error("output register occupied while a division runs");

endmodule

### rtl/esip_dpath.sv
module esip_dpath import esip_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [2:0]            switch_code_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_sts_t               sts_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  injector_on_o,
  output logic [15:0]           speed_o,
  output logic                  speed_updated_o
);

  // Configuration registers.
  logic [7:0]  ticks_per_unit_q;
  logic [15:0] period_limit_q;
  logic [23:0] speed_numerator_q;
  logic [7:0]  base_pulse_units_q;

  // Block state.
  logic [7:0]  prescale_q, prescale_d;
  logic [15:0] period_q, period_d;
  logic        active_q, active_d;
  logic [15:0] pulse_cnt_q, pulse_cnt_d;
  logic [15:0] speed_q;

  // Divider.
  logic [DIV_STEPS-1:0] dq_q;
  logic [15:0]          rem_q;
  logic [15:0]          dvsr_q;
  logic [16:0]          rem_sh;
  logic                 q_bit;
  logic [15:0]          rem_nx;
  logic [DIV_STEPS-1:0] dq_nx;
  logic [15:0]          quot_sat;

  // Output register and the injector level held across a division.
  logic        out_valid_q;
  logic        out_inj_q;
  logic [15:0] out_speed_q;
  logic        out_upd_q;
  logic        pend_inj_q;

  // Tick arithmetic.
  logic [8:0]  pre_inc;
  logic        unit_wrap;
  logic [16:0] period_inc;
  logic [15:0] pulse_limit;
  logic        act_mid;
  logic [15:0] cnt_mid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_per_unit_q   <= TICKS_PER_UNIT_RST;
      period_limit_q     <= PERIOD_LIMIT_RST;
      speed_numerator_q  <= SPEED_NUMERATOR_RST;
      base_pulse_units_q <= BASE_PULSE_UNITS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TICKS_PER_UNIT:   ticks_per_unit_q   <= cfg_data_i[7:0];
        CFG_PERIOD_LIMIT:     period_limit_q     <= cfg_data_i[15:0];
        CFG_SPEED_NUMERATOR:  speed_numerator_q  <= cfg_data_i[23:0];
        CFG_BASE_PULSE_UNITS: base_pulse_units_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign pulse_limit = 16'(base_pulse_units_q) << switch_code_i;
  assign pre_inc     = {1'b0, prescale_q} + 9'd1;
  assign unit_wrap   = (pre_inc >= {1'b0, ticks_per_unit_q});
  assign period_inc  = {1'b0, period_q} + {16'd0, unit_wrap};

  always_comb begin
    prescale_d  = prescale_q;
    period_d    = period_q;
    act_mid     = active_q;
    cnt_mid     = pulse_cnt_q;
    if (cmd_i.tick_go) begin
      prescale_d = unit_wrap ? 8'd0 : pre_inc[7:0];
      // A lowered limit also clamps a count that did not advance.
      period_d   = (period_inc > {1'b0, period_limit_q}) ? period_limit_q : period_inc[15:0];
      if (unit_wrap && active_q && (pulse_cnt_q != COUNT_MAX)) begin
        cnt_mid = pulse_cnt_q + 16'd1;
      end
    end else if (cmd_i.edge_go) begin
      period_d = '0;
      act_mid  = 1'b1;
    end
    active_d    = act_mid;
    pulse_cnt_d = cnt_mid;
    if ((cmd_i.tick_go || cmd_i.edge_go) && act_mid && (cnt_mid > pulse_limit)) begin
      active_d    = 1'b0;
      pulse_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q  <= '0;
      period_q    <= '0;
      active_q    <= 1'b0;
      pulse_cnt_q <= '0;
    end else begin
      prescale_q  <= prescale_d;
      period_q    <= period_d;
      active_q    <= active_d;
      pulse_cnt_q <= pulse_cnt_d;
    end
  end

  // Restoring division of numerator/2 by the period count. A zero divisor
  // yields all ones, which saturates like any oversized quotient.
  assign rem_sh   = {rem_q, dq_q[DIV_STEPS-1]};
  assign q_bit    = (rem_sh >= {1'b0, dvsr_q});
  assign rem_nx   = q_bit ? 16'(rem_sh - {1'b0, dvsr_q}) : rem_sh[15:0];
  assign dq_nx    = {dq_q[DIV_STEPS-2:0], q_bit};
  assign quot_sat = (dq_nx[DIV_STEPS-1:16] != '0) ? SPEED_MAX : dq_nx[15:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.edge_go) begin
      dq_q       <= speed_numerator_q[23:1];
      rem_q      <= '0;
      dvsr_q     <= period_q;
      pend_inj_q <= active_d;
    end else if (cmd_i.div_step) begin
      dq_q  <= dq_nx;
      rem_q <= rem_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= '0;
    end else if (cmd_i.div_done) begin
      speed_q <= quot_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.tick_go || cmd_i.div_done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_go) begin
      out_inj_q   <= active_d;
      out_speed_q <= speed_q;
      out_upd_q   <= 1'b0;
    end else if (cmd_i.div_done) begin
      out_inj_q   <= pend_inj_q;
      out_speed_q <= quot_sat;
      out_upd_q   <= 1'b1;
    end
  end

  assign sts_o.out_full  = out_valid_q && out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign injector_on_o   = out_inj_q;
  assign speed_o         = out_speed_q;
  assign speed_updated_o = out_upd_q;

endmodule

### rtl/engine_speed_injection_pulse_unit.sv
// Channel   Direction  Handshake               Word
// in        input      in_valid_i/in_stall_o   command_i, switch_code_i
// out       output     out_valid_o/out_stall_i injector_on_o, speed_o, speed_updated_o
// cfg       input      cfg_we_i                cfg_index_i, cfg_data_i
//
// A tick word's result is registered at the accepting edge.
// An edge word is accepted and then runs through 23 steps of the serial divider.
// Reset restores the register defaults and clears all counters and the output valid flag.
// A new word is taken only when no division runs and the output register is
// empty or being taken in the same cycle.
module engine_speed_injection_pulse_unit import esip_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [2:0]            switch_code_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  injector_on_o,
  output logic [15:0]           speed_o,
  output logic                  speed_updated_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  esip_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  esip_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .switch_code_i   (switch_code_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .injector_on_o   (injector_on_o),
    .speed_o         (speed_o),
    .speed_updated_o (speed_updated_o)
  );

endmodule

### dv/tb.sv
module tb;
  import esip_pkg::*;

  typedef struct {
    logic        cmd;
    logic [2:0]  code;
    int unsigned gap;
  } sensor_word_t;

  typedef struct packed {
    logic        inj;
    logic [15:0] spd;
    logic        upd;
  } inj_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  command_i;
  logic [2:0]            switch_code_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  injector_on_o;
  logic [15:0]           speed_o;
  logic                  speed_updated_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  engine_speed_injection_pulse_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .switch_code_i   (switch_code_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .injector_on_o   (injector_on_o),
    .speed_o         (speed_o),
    .speed_updated_o (speed_updated_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Shadow copy of the engine timer registers and counters.
  logic [7:0]  tpu_cfg   = TICKS_PER_UNIT_RST;
  logic [15:0] lim_cfg   = PERIOD_LIMIT_RST;
  logic [23:0] num_cfg   = SPEED_NUMERATOR_RST;
  logic [7:0]  base_cfg  = BASE_PULSE_UNITS_RST;
  logic [7:0]  pre_cnt   = '0;
  logic [15:0] per_cnt   = '0;
  logic        pulse_on  = 1'b0;
  logic [15:0] pulse_cnt = '0;
  logic [15:0] spd_val   = '0;

  sensor_word_t sensor_word_q[$];
  inj_result_t  speed_inj_q[$];
  sensor_word_t staged_w;
  logic         staged = 1'b0;
  int unsigned  gap_left = 0;

  inj_result_t  want;
  int unsigned  stall_left = 0;
  int unsigned  stall_len;
  int unsigned  next_hold_at = 300;

  int unsigned  n_results = 0;
  int unsigned  n_edges = 0;
  int unsigned  n_sat = 0;
  int unsigned  n_pulse_ends = 0;
  int unsigned  n_cfg = 0;
  int unsigned  mismatches = 0;
  logic         last_inj = 1'b0;

  function automatic inj_result_t advance_engine(logic cmd, logic [2:0] code);
    logic [8:0]  pre_next;
    logic [16:0] per_next;
    logic [16:0] twice;
    logic [23:0] quo;
    logic [15:0] pulse_len;
    inj_result_t r;
    if (cmd == CMD_EDGE) begin
      twice = {per_cnt, 1'b0};
      if (twice == '0) begin
        spd_val = SPEED_MAX;
      end else begin
        quo = num_cfg / twice;
        spd_val = (quo > 24'h00FFFF) ? SPEED_MAX : quo[15:0];
      end
      per_cnt  = '0;
      pulse_on = 1'b1;
    end else begin
      pre_next = {1'b0, pre_cnt} + 9'd1;
      per_next = {1'b0, per_cnt};
      if (pre_next >= {1'b0, tpu_cfg}) begin
        pre_cnt  = '0;
        per_next = per_next + 17'd1;
        if (pulse_on && pulse_cnt < COUNT_MAX) pulse_cnt = pulse_cnt + 16'd1;
      end else begin
        pre_cnt = pre_next[7:0];
      end
      if (per_next > {1'b0, lim_cfg}) per_next = {1'b0, lim_cfg};
      per_cnt = per_next[15:0];
    end
    pulse_len = {8'd0, base_cfg} << code;
    if (pulse_on && pulse_cnt > pulse_len) begin
      pulse_cnt = '0;
      pulse_on  = 1'b0;
    end
    r.inj = pulse_on;
    r.spd = spd_val;
    r.upd = cmd;
    return r;
  endfunction

  // Mostly back to back, sometimes a short pause, now and then a long one.
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("tb: mismatch %0d: %s", mismatches, msg);
  endtask

  always #5 clk_i = ~clk_i;

  // Driver: presents queued words, holding each one until it is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o)
        speed_inj_q.push_back(advance_engine(command_i, switch_code_i));
      if (!in_valid_i || !in_stall_o) begin
        if (!staged && sensor_word_q.size() != 0) begin
          staged_w = sensor_word_q.pop_front();
          staged   = 1'b1;
          gap_left = staged_w.gap;
        end
        if (staged && gap_left == 0) begin
          in_valid_i    <= 1'b1;
          command_i     <= staged_w.cmd;
          switch_code_i <= staged_w.code;
          staged = 1'b0;
        end else begin
          in_valid_i <= 1'b0;
          if (staged) gap_left--;
        end
      end
    end
  end

  // Monitor: checks each taken result word and throttles the output side.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (speed_updated_o) n_edges++;
        if (speed_updated_o && speed_o == SPEED_MAX) n_sat++;
        if (last_inj && !injector_on_o) n_pulse_ends++;
        last_inj = injector_on_o;
        if (speed_inj_q.size() == 0) begin
          note_mismatch($sformatf("unexpected word inj=%0b speed=%0d upd=%0b",
                                  injector_on_o, speed_o, speed_updated_o));
        end else begin
          want = speed_inj_q.pop_front();
          if (want.inj !== injector_on_o || want.spd !== speed_o ||
              want.upd !== speed_updated_o)
            note_mismatch($sformatf({"word %0d: expected inj=%0b speed=%0d upd=%0b, ",
                                     "got inj=%0b speed=%0d upd=%0b"},
                                    n_results, want.inj, want.spd, want.upd,
                                    injector_on_o, speed_o, speed_updated_o));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (n_results >= next_hold_at) begin
          // Long hold-off so the block backs up and stalls its input.
          stall_len = 250;
          next_hold_at += 400;
        end else if ((n_results >> 7) % 5 == 3) begin
          stall_len = 0;
        end else begin
          stall_len = pick_idle();
        end
        out_stall_i <= (stall_len != 0);
        stall_left = (stall_len != 0) ? stall_len - 1 : 0;
      end
    end
  end

  task automatic push_word(logic cmd, logic [2:0] code, bit bursty);
    sensor_word_t w;
    w.cmd  = cmd;
    w.code = code;
    w.gap  = bursty ? pick_idle() : 0;
    sensor_word_q.push_back(w);
  endtask

  task automatic wait_idle();
    while (sensor_word_q.size() != 0 || staged || in_valid_i || speed_inj_q.size() != 0)
      @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      CFG_TICKS_PER_UNIT:   tpu_cfg  = data[7:0];
      CFG_PERIOD_LIMIT:     lim_cfg  = data[15:0];
      CFG_SPEED_NUMERATOR:  num_cfg  = data[23:0];
      CFG_BASE_PULSE_UNITS: base_cfg = data[7:0];
      default: ;
    endcase
    n_cfg++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_engine(int unsigned tpu, int unsigned lim, int unsigned num,
                            int unsigned base);
    wait_idle();
    write_reg(CFG_TICKS_PER_UNIT, CFG_DATA_W'(tpu));
    write_reg(CFG_PERIOD_LIMIT, CFG_DATA_W'(lim));
    write_reg(CFG_SPEED_NUMERATOR, CFG_DATA_W'(num));
    write_reg(CFG_BASE_PULSE_UNITS, CFG_DATA_W'(base));
  endtask

  // Runs of ticks broken by sensor edges; the switch code mostly holds steady.
  task automatic run_engine(int unsigned n, int unsigned edge_pct, int unsigned code_max,
                            int unsigned code_pct, bit bursty);
    logic [2:0] code;
    code = 3'($urandom_range(0, code_max));
    repeat (n) begin
      if ($urandom_range(0, 99) < code_pct) code = 3'($urandom_range(0, code_max));
      push_word(($urandom_range(0, 99) < edge_pct) ? CMD_EDGE : CMD_TICK, code, bursty);
    end
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    command_i     = CMD_TICK;
    switch_code_i = '0;
    out_stall_i   = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_TICKS_PER_UNIT;
    cfg_data_i    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero period, saturated quotient, edge inside a pulse,
    // switch code change mid pulse, lowered limit clamp.
    write_reg(CFG_TICKS_PER_UNIT, CFG_DATA_W'(1));
    write_reg(CFG_BASE_PULSE_UNITS, CFG_DATA_W'(2));
    push_word(CMD_EDGE, 3'd0, 1'b1);
    push_word(CMD_TICK, 3'd0, 1'b1);
    push_word(CMD_EDGE, 3'd0, 1'b1);
    repeat (3) push_word(CMD_TICK, 3'd0, 1'b1);
    push_word(CMD_EDGE, 3'd7, 1'b1);
    repeat (2) push_word(CMD_TICK, 3'd7, 1'b1);
    push_word(CMD_TICK, 3'd0, 1'b1);
    repeat (6) push_word(CMD_TICK, 3'd5, 1'b0);
    wait_idle();
    write_reg(CFG_PERIOD_LIMIT, CFG_DATA_W'(3));
    write_reg(CFG_SPEED_NUMERATOR, CFG_DATA_W'(1000));
    push_word(CMD_TICK, 3'd2, 1'b1);
    push_word(CMD_EDGE, 3'd2, 1'b1);
    repeat (4) push_word(CMD_TICK, 3'd2, 1'b1);
    push_word(CMD_EDGE, 3'd1, 1'b1);

    // Random phases across register extremes and typical settings.
    set_engine(1, 65535, 16777215, 1);
    run_engine(140, 8, 7, 5, 1'b1);
    set_engine(255, 1, 1, 255);
    run_engine(100, 5, 7, 10, 1'b1);
    set_engine(0, 0, 0, 0);
    run_engine(120, 10, 7, 10, 1'b0);
    set_engine(2, 20, 5000, 3);
    run_engine(140, 6, 3, 5, 1'b1);
    repeat (3) begin
      set_engine($urandom_range(1, 4), $urandom_range(8, 400),
                 $urandom_range(0, 24'hFFFFFF), $urandom_range(1, 8));
      run_engine(140, 7, 4, 5, 1'b1);
    end
    run_engine(60, 40, 7, 30, 1'b1);

    wait_idle();
    $display("tb: %0d result words checked, %0d sensor edges, %0d saturated speeds",
             n_results, n_edges, n_sat);
    $display("tb: %0d injection pulses ended, %0d register writes", n_pulse_ends, n_cfg);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

### filelist.f
rtl/esip_pkg.sv
rtl/esip_ctrl.sv
rtl/esip_dpath.sv
rtl/engine_speed_injection_pulse_unit.sv
dv/tb.sv
